// ----- src/totp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TOTP HMAC-SHA1 package
// Shared types, constants and round functions for the one-time code pipeline.
// ----------------------------------------------------------------------------
package totp_pkg;

    // Key length in bytes (1 to 20).
    localparam int KEY_BYTES = 20;

    localparam int STEP_W = 28;
    localparam int CODE_W = 27;
    localparam int VAL_W  = 31;

    // Sideband carried through a hash pipeline: a hash state and the time step.
    localparam int SIDE_W = 160 + STEP_W;

    // Reciprocal of 30 for 32-bit dividends: n / 30 = (n * DIV30_MAGIC) >> 36.
    localparam logic [31:0] DIV30_MAGIC = 32'h8888_8889;
    localparam int          DIV30_SHIFT = 36;

    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5C;

    // Message lengths in bits for the second block of each hash.
    localparam logic [63:0] INNER_LEN_BITS = 64'd576;
    localparam logic [63:0] OUTER_LEN_BITS = 64'd672;

    // Register indexes of the configuration port.
    typedef enum logic [7:0] {
        REG_KEY_HEAD    = 8'd0,
        REG_KEY_MIDDLE  = 8'd1,
        REG_KEY_TAIL    = 8'd2,
        REG_DIGIT_COUNT = 8'd3
    } cfg_reg_t;

    // Five-word hash state, word 0 in the top bits.
    typedef logic [0:4][31:0]  hstate_t;
    // Sixteen-word message window, word 0 in the top bits.
    typedef logic [0:15][31:0] sched_t;

    localparam hstate_t SHA1_INIT = {32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE,
                                     32'h1032_5476, 32'hC3D2_E1F0};

    function automatic logic [31:0] sha1_f(input logic [6:0] rnd,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
        logic [31:0] res;
        if (rnd < 7'd20) begin
            res = (b & c) | (~b & d);
        end else if (rnd < 7'd40) begin
            res = b ^ c ^ d;
        end else if (rnd < 7'd60) begin
            res = (b & c) | (b & d) | (c & d);
        end else begin
            res = b ^ c ^ d;
        end
        return res;
    endfunction

    function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
        logic [31:0] res;
        if (rnd < 7'd20) begin
            res = 32'h5A82_7999;
        end else if (rnd < 7'd40) begin
            res = 32'h6ED9_EBA1;
        end else if (rnd < 7'd60) begin
            res = 32'h8F1B_BCDC;
        end else begin
            res = 32'hCA62_C1D6;
        end
        return res;
    endfunction

    // First HMAC block: key bytes (zero past the key length) xor the pad byte.
    function automatic logic [511:0] key_block(input logic [63:0] head,
                                               input logic [63:0] middle,
                                               input logic [31:0] tail,
                                               input logic [7:0]  pad);
        logic [159:0] kv;
        logic [511:0] res;
        kv  = {head, middle, tail};
        res = {64{pad}};
        for (int i = 0; i < KEY_BYTES; i++) begin
            res[511 - 8 * i -: 8] = kv[159 - 8 * i -: 8] ^ pad;
        end
        return res;
    endfunction

    // Ten to the power of the digit count, saturated to 1..8 digits.
    function automatic logic [CODE_W-1:0] pow10(input logic [3:0] digits);
        logic [CODE_W-1:0] res;
        case (digits)
            4'd0, 4'd1: res = 27'd10;
            4'd2:       res = 27'd100;
            4'd3:       res = 27'd1000;
            4'd4:       res = 27'd10000;
            4'd5:       res = 27'd100000;
            4'd6:       res = 27'd1000000;
            4'd7:       res = 27'd10000000;
            default:    res = 27'd100000000;
        endcase
        return res;
    endfunction

    // floor(2^32 / 10^digits), same saturation as pow10.
    function automatic logic [31:0] recip10(input logic [3:0] digits);
        logic [31:0] res;
        case (digits)
            4'd0, 4'd1: res = 32'd429496729;
            4'd2:       res = 32'd42949672;
            4'd3:       res = 32'd4294967;
            4'd4:       res = 32'd429496;
            4'd5:       res = 32'd42949;
            4'd6:       res = 32'd4294;
            4'd7:       res = 32'd429;
            default:    res = 32'd42;
        endcase
        return res;
    endfunction

endpackage

// ----- src/totp_sha1_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 block pipeline
// One compression of a 512-bit block, one round per register stage, then a
// final stage that adds the chaining state. A sideband rides along unchanged.
// ----------------------------------------------------------------------------
module totp_sha1_pipe
    import totp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  hstate_t           h_in,
    input  logic [511:0]      blk_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output hstate_t           h_out,
    output logic [SIDE_W-1:0] side_out
);

    // Stage views: index 0 is the input, index r+1 the register after round r.
    logic              v_stg    [0:80];
    logic [31:0]       a_stg    [0:80];
    logic [31:0]       b_stg    [0:80];
    logic [31:0]       c_stg    [0:80];
    logic [31:0]       d_stg    [0:80];
    logic [31:0]       e_stg    [0:80];
    sched_t            w_stg    [0:80];
    hstate_t           h_stg    [0:80];
    logic [SIDE_W-1:0] side_stg [0:80];

    logic              out_valid_reg;
    hstate_t           h_out_reg;
    logic [SIDE_W-1:0] side_out_reg;

    assign v_stg[0]    = in_valid;
    assign a_stg[0]    = h_in[0];
    assign b_stg[0]    = h_in[1];
    assign c_stg[0]    = h_in[2];
    assign d_stg[0]    = h_in[3];
    assign e_stg[0]    = h_in[4];
    assign w_stg[0]    = sched_t'(blk_in);
    assign h_stg[0]    = h_in;
    assign side_stg[0] = side_in;

    // One round per stage; the window slides by one word each round.
    for (genvar r = 0; r < 80; r++) begin : g_round
        logic              v_reg;
        logic [31:0]       a_reg, b_reg, c_reg, d_reg, e_reg;
        sched_t            w_reg;
        hstate_t           h_reg;
        logic [SIDE_W-1:0] side_reg;
        logic [31:0]       a_next;
        logic [31:0]       w16_next;
        logic [31:0]       mix_w;

        always_comb begin
            a_next = {a_stg[r][26:0], a_stg[r][31:27]}
                   + sha1_f(7'(r), b_stg[r], c_stg[r], d_stg[r])
                   + e_stg[r] + sha1_k(7'(r)) + w_stg[r][0];
            mix_w    = w_stg[r][13] ^ w_stg[r][8] ^ w_stg[r][2] ^ w_stg[r][0];
            w16_next = {mix_w[30:0], mix_w[31]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= v_stg[r];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                a_reg    <= a_next;
                b_reg    <= a_stg[r];
                c_reg    <= {b_stg[r][1:0], b_stg[r][31:2]};
                d_reg    <= c_stg[r];
                e_reg    <= d_stg[r];
                w_reg    <= {w_stg[r][1:15], w16_next};
                h_reg    <= h_stg[r];
                side_reg <= side_stg[r];
            end
        end

        assign v_stg[r+1]    = v_reg;
        assign a_stg[r+1]    = a_reg;
        assign b_stg[r+1]    = b_reg;
        assign c_stg[r+1]    = c_reg;
        assign d_stg[r+1]    = d_reg;
        assign e_stg[r+1]    = e_reg;
        assign w_stg[r+1]    = w_reg;
        assign h_stg[r+1]    = h_reg;
        assign side_stg[r+1] = side_reg;
    end

    // Final stage: add the working words to the chaining state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v_stg[80];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_out_reg[0] <= h_stg[80][0] + a_stg[80];
            h_out_reg[1] <= h_stg[80][1] + b_stg[80];
            h_out_reg[2] <= h_stg[80][2] + c_stg[80];
            h_out_reg[3] <= h_stg[80][3] + d_stg[80];
            h_out_reg[4] <= h_stg[80][4] + e_stg[80];
            side_out_reg <= side_stg[80];
        end
    end

    assign out_valid = out_valid_reg;
    assign h_out     = h_out_reg;
    assign side_out  = side_out_reg;

endmodule

// ----- src/totp_hmac_sha1_code_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TOTP HMAC-SHA1 code generator
// Time step, HMAC-SHA1 of the step, dynamic truncation and decimal modulo.
// ----------------------------------------------------------------------------
// The block accepts one Unix time per cycle while s_tready is high and returns
// its one-time code and time step in input order via three SHA-1 compressions
// in series of 81 stages each (the two key blocks run side by side), plus two
// stages for the divide by 30, one for truncation and four for the modulo. A
// low m_tready freezes the whole pipeline, so s_tready follows it; nothing is
// dropped or repeated. Keys and digit count must be written through the cfg
// port only while no item is in flight, unenforced; cfg_ready is always high.
// ----------------------------------------------------------------------------
module totp_hmac_sha1_code_top
    import totp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] epoch_seconds
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [26:0] code_value, [54:27] time_step, [55] zero
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic        en;

    logic [63:0] key_head_reg;
    logic [63:0] key_middle_reg;
    logic [31:0] key_tail_reg;
    logic [3:0]  digit_count_reg;

    logic              div_valid_reg;
    logic [63:0]       div_prod_reg;
    logic              step_valid_reg;
    logic [STEP_W-1:0] step_reg;

    logic              i1_valid, o1_valid, i2_valid, o2_valid;
    hstate_t           i1_h, o1_h, i2_h, o2_h;
    logic [SIDE_W-1:0] i1_side, o1_side, i2_side, o2_side;
    logic [SIDE_W-1:0] first_side;
    logic [511:0]      ipad_blk, opad_blk, inner2_blk, outer2_blk;
    logic [159:0]      hash_w;
    logic [STEP_W-1:0] i2_step_w;

    logic              trunc_valid_reg;
    logic [VAL_W-1:0]  trunc_val_reg;
    logic [STEP_W-1:0] trunc_step_reg;
    logic [31:0]       trunc_word;

    logic              m1_valid_reg;
    logic [62:0]       m1_prod_reg;
    logic [VAL_W-1:0]  m1_val_reg;
    logic [CODE_W-1:0] m1_div_reg;
    logic [STEP_W-1:0] m1_step_reg;

    logic              m2_valid_reg;
    logic [VAL_W-1:0]  m2_qd_reg;
    logic [VAL_W-1:0]  m2_val_reg;
    logic [CODE_W-1:0] m2_div_reg;
    logic [STEP_W-1:0] m2_step_reg;
    logic [57:0]       m2_qd_full;

    logic              m3_valid_reg;
    logic [CODE_W:0]   m3_rem_reg;
    logic [CODE_W-1:0] m3_div_reg;
    logic [STEP_W-1:0] m3_step_reg;
    logic [VAL_W-1:0]  m3_diff;

    logic              out_valid_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic [STEP_W-1:0] out_step_reg;
    logic [CODE_W:0]   code_next;

    // The whole pipeline advances when the output register can take an item.
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_head_reg    <= '0;
            key_middle_reg  <= '0;
            key_tail_reg    <= '0;
            digit_count_reg <= 4'd6;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_KEY_HEAD:    key_head_reg    <= cfg_data;
                REG_KEY_MIDDLE:  key_middle_reg  <= cfg_data;
                REG_KEY_TAIL:    key_tail_reg    <= cfg_data[31:0];
                REG_DIGIT_COUNT: digit_count_reg <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    // Divide by 30 as a multiply by the reciprocal, then a shift.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_valid_reg  <= 1'b0;
            step_valid_reg <= 1'b0;
        end else if (en) begin
            div_valid_reg  <= s_tvalid;
            step_valid_reg <= div_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_prod_reg <= s_tdata * DIV30_MAGIC;
            step_reg     <= div_prod_reg[DIV30_SHIFT +: STEP_W];
        end
    end

    // Key blocks: inner and outer first compressions run side by side.
    assign ipad_blk   = key_block(key_head_reg, key_middle_reg, key_tail_reg, IPAD);
    assign opad_blk   = key_block(key_head_reg, key_middle_reg, key_tail_reg, OPAD);
    assign first_side = {160'd0, step_reg};

    totp_sha1_pipe u_inner1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (step_valid_reg),
        .h_in      (SHA1_INIT),
        .blk_in    (ipad_blk),
        .side_in   (first_side),
        .out_valid (i1_valid),
        .h_out     (i1_h),
        .side_out  (i1_side)
    );

    totp_sha1_pipe u_outer1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (step_valid_reg),
        .h_in      (SHA1_INIT),
        .blk_in    (opad_blk),
        .side_in   (first_side),
        .out_valid (o1_valid),
        .h_out     (o1_h),
        .side_out  (o1_side)
    );

    // Inner second block: 8-byte counter, padding and message length.
    assign i2_step_w  = i1_side[STEP_W-1:0];
    assign inner2_blk = {32'd0, 4'd0, i2_step_w, 8'h80, 376'd0, INNER_LEN_BITS};

    totp_sha1_pipe u_inner2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (i1_valid && o1_valid),
        .h_in      (i1_h),
        .blk_in    (inner2_blk),
        .side_in   ({o1_h, o1_side[STEP_W-1:0]}),
        .out_valid (i2_valid),
        .h_out     (i2_h),
        .side_out  (i2_side)
    );

    // Outer second block: inner digest, padding and message length.
    assign outer2_blk = {i2_h, 8'h80, 280'd0, OUTER_LEN_BITS};

    totp_sha1_pipe u_outer2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (i2_valid),
        .h_in      (i2_side[SIDE_W-1:STEP_W]),
        .blk_in    (outer2_blk),
        .side_in   ({160'd0, i2_side[STEP_W-1:0]}),
        .out_valid (o2_valid),
        .h_out     (o2_h),
        .side_out  (o2_side)
    );

    // Dynamic truncation: low nibble of byte 19 picks the 4-byte window.
    assign hash_w     = o2_h;
    assign trunc_word = hash_w[159 - 8 * hash_w[3:0] -: 32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trunc_valid_reg <= 1'b0;
            m1_valid_reg    <= 1'b0;
            m2_valid_reg    <= 1'b0;
            m3_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else if (en) begin
            trunc_valid_reg <= o2_valid;
            m1_valid_reg    <= trunc_valid_reg;
            m2_valid_reg    <= m1_valid_reg;
            m3_valid_reg    <= m2_valid_reg;
            out_valid_reg   <= m3_valid_reg;
        end
    end

    // Modulo 10^digits: estimated quotient by reciprocal, one correction step.
    assign m2_qd_full = m1_prod_reg[62:32] * m1_div_reg;
    assign m3_diff    = m2_val_reg - m2_qd_reg;
    assign code_next  = (m3_rem_reg >= {1'b0, m3_div_reg})
                      ? m3_rem_reg - {1'b0, m3_div_reg} : m3_rem_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            trunc_val_reg  <= trunc_word[VAL_W-1:0];
            trunc_step_reg <= o2_side[STEP_W-1:0];

            m1_prod_reg    <= trunc_val_reg * recip10(digit_count_reg);
            m1_val_reg     <= trunc_val_reg;
            m1_div_reg     <= pow10(digit_count_reg);
            m1_step_reg    <= trunc_step_reg;

            m2_qd_reg      <= m2_qd_full[VAL_W-1:0];
            m2_val_reg     <= m1_val_reg;
            m2_div_reg     <= m1_div_reg;
            m2_step_reg    <= m1_step_reg;

            m3_rem_reg     <= m3_diff[CODE_W:0];
            m3_div_reg     <= m2_div_reg;
            m3_step_reg    <= m2_step_reg;

            out_code_reg   <= code_next[CODE_W-1:0];
            out_step_reg   <= m3_step_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_step_reg, out_code_reg};

endmodule
